// File: sv/kmsd_pkg.sv
// Shared types and constants for the key matrix scan debouncer.
`timescale 1ns / 1ps
package kmsd_pkg;

    localparam int COL_W  = 3;
    localparam int ROW_W  = 12;
    localparam int CNT_W  = 8;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd5;

    // Register index taken from paddr[2] (one 32-bit word per register).
    localparam logic REG_DEBOUNCE = 1'b0;

    typedef struct packed {
        logic             col_ok;
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] rows;
    } kmsd_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] stable_bits;
        logic             settled;
    } kmsd_result_t;

    typedef struct packed {
        logic             fire;
        logic             copy;
        logic [CNT_W-1:0] countdown;
    } kmsd_back_status_t;

endpackage

// File: sv/kmsd_fifo.sv
// Two-entry queue with simultaneous push and pop.
`timescale 1ns / 1ps
module kmsd_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_wr;
    logic         do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/kmsd_front.sv
// Front end: takes column beats, classifies and masks them, queues them.
`timescale 1ns / 1ps
module kmsd_front
    import kmsd_pkg::*;
#(
    parameter int NUM_COLUMNS = 6,
    parameter int NUM_ROWS    = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [COL_W-1:0] column,
    input  logic [ROW_W-1:0] row_bits,
    output kmsd_item_t       item,
    output logic             item_valid,
    input  logic             item_pop
);

    // 6 bits cover a column count of up to 63
    localparam int CMP_W = 6;
    localparam logic [ROW_W-1:0] ROW_MASK =
        (NUM_ROWS >= ROW_W) ? {ROW_W{1'b1}} : ROW_W'((1 << NUM_ROWS) - 1);

    kmsd_item_t cls;
    logic       item_empty;

    always_comb
    begin
        cls.col_ok = (CMP_W'(column) < CMP_W'(NUM_COLUMNS));
        cls.last   = (CMP_W'(column) == CMP_W'(NUM_COLUMNS - 1));
        cls.col    = column;
        cls.rows   = row_bits & ROW_MASK;
    end

    kmsd_fifo #(
        .W($bits(kmsd_item_t))
    ) u_item_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls),
        .full    (full),
        .rd_en   (item_pop),
        .rd_data (item),
        .empty   (item_empty)
    );

    assign item_valid = !item_empty;

endmodule

// File: sv/kmsd_back.sv
// Back end: pending/stable matrix, shared countdown and result queue.
`timescale 1ns / 1ps
module kmsd_back
    import kmsd_pkg::*;
#(
    parameter int NUM_COLUMNS = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  kmsd_item_t        item,
    input  logic              item_valid,
    output logic              item_pop,
    input  logic [CNT_W-1:0]  debounce_scans,
    output logic              empty,
    input  logic              pop,
    output kmsd_result_t      result,
    output kmsd_back_status_t status
);

    localparam int IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

    logic [ROW_W-1:0] pending_reg  [NUM_COLUMNS];
    logic [ROW_W-1:0] pending_next [NUM_COLUMNS];
    logic [ROW_W-1:0] stable_reg   [NUM_COLUMNS];
    logic [ROW_W-1:0] stable_next  [NUM_COLUMNS];
    logic [CNT_W-1:0] countdown_reg;
    logic [CNT_W-1:0] countdown_next;

    logic [IDX_W-1:0] idx;
    logic             res_full;
    logic             fire;
    logic             changed;
    logic [CNT_W-1:0] cd_load;
    logic             dec;
    logic             copy;
    kmsd_result_t     res;

    assign fire     = item_valid && !res_full;
    assign item_pop = fire;
    assign idx      = IDX_W'(item.col);

    always_comb
    begin
        changed = item.col_ok && (pending_reg[idx] != item.rows);
        cd_load = changed ? debounce_scans : countdown_reg;
        dec     = item.col_ok && item.last && (cd_load != '0);
        copy    = dec && (cd_load == CNT_W'(1));

        countdown_next = countdown_reg;
        if (fire)
        begin
            countdown_next = dec ? cd_load - CNT_W'(1) : cd_load;
        end

        for (int i = 0; i < NUM_COLUMNS; i++)
        begin
            pending_next[i] = pending_reg[i];
            stable_next[i]  = stable_reg[i];
            if (fire && changed && (idx == IDX_W'(i)))
            begin
                pending_next[i] = item.rows;
            end
        end
        if (fire && copy)
        begin
            for (int i = 0; i < NUM_COLUMNS; i++)
            begin
                stable_next[i] = pending_next[i];
            end
        end

        // after a copy this column's stable value is the incoming rows
        if (!item.col_ok)
        begin
            res.stable_bits = '0;
        end
        else if (copy)
        begin
            res.stable_bits = item.rows;
        end
        else
        begin
            res.stable_bits = stable_reg[idx];
        end
        res.settled = (fire ? (dec ? cd_load - CNT_W'(1) : cd_load) : countdown_reg) == '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg <= DEBOUNCE_RESET;
            for (int i = 0; i < NUM_COLUMNS; i++)
            begin
                pending_reg[i] <= '0;
                stable_reg[i]  <= '0;
            end
        end
        else
        begin
            countdown_reg <= countdown_next;
            for (int i = 0; i < NUM_COLUMNS; i++)
            begin
                pending_reg[i] <= pending_next[i];
                stable_reg[i]  <= stable_next[i];
            end
        end
    end

    kmsd_fifo #(
        .W($bits(kmsd_result_t))
    ) u_result_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fire),
        .wr_data (res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

    assign status.fire      = fire;
    assign status.copy      = fire && copy;
    assign status.countdown = countdown_reg;

endmodule

// File: sv/key_matrix_scan_debouncer_unit.sv
// Top level of the key matrix scan debouncer.
`timescale 1ns / 1ps
// Usage:
//   Input channel (push/full): one beat per scanned column, carrying the
//   column index and active-high row bits. A beat is taken when push is high
//   and full is low.
//   Result channel (empty/pop): one beat per input beat, in order, with the
//   debounced row bits of that column and the settled flag. The oldest result
//   sits on the ports while empty is low and leaves when pop is high.
//   Config (APB): debounce_scans at byte address 0; pready is always high.
//   Write it only while no beat is in flight.
// Path: an accepted beat is written into the front queue, then the back end's
//   update writes its result into the result queue while that queue has room;
//   the result then sits on the ports until popped.
// Throughput: one beat per cycle while the result queue is not full; the
//   compare, countdown update and parallel matrix copy happen in one update.
// Reset: pending and stable matrices clear to zero, countdown and
//   debounce_scans load 5, both queues empty.
// Stall: when pop stays low the result queue fills, the back end stops
//   draining the front queue, and full rises once that queue holds two beats.
module key_matrix_scan_debouncer_unit
    import kmsd_pkg::*;
#(
    parameter int NUM_COLUMNS = 6,
    parameter int NUM_ROWS    = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              push,
    output logic              full,
    input  logic [COL_W-1:0]  column,
    input  logic [ROW_W-1:0]  row_bits,
    output logic              empty,
    input  logic              pop,
    output logic [ROW_W-1:0]  stable_bits,
    output logic              settled
);

    logic [CNT_W-1:0]  debounce_reg;
    logic [CNT_W-1:0]  debounce_next;
    logic              cfg_wr;
    kmsd_item_t        item;
    logic              item_valid;
    logic              item_pop;
    kmsd_result_t      result;
    kmsd_back_status_t back_st;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        debounce_next = debounce_reg;
        if (cfg_wr && (paddr[2] == REG_DEBOUNCE))
        begin
            debounce_next = pwdata[CNT_W-1:0];
        end
        prdata = '0;
        if (paddr[2] == REG_DEBOUNCE)
        begin
            prdata = DATA_W'(debounce_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else
        begin
            debounce_reg <= debounce_next;
        end
    end

    kmsd_front #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .column     (column),
        .row_bits   (row_bits),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    kmsd_back #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .item_valid     (item_valid),
        .item_pop       (item_pop),
        .debounce_scans (debounce_reg),
        .empty          (empty),
        .pop            (pop),
        .result         (result),
        .status         (back_st)
    );

    assign stable_bits = result.stable_bits;
    assign settled     = result.settled;

    // an accepted beat is waiting in the front queue on the next cycle
    a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> item_valid)
        else $error("accepted beat missing from front queue");

    a_back_source: assert property (@(posedge clk) disable iff (!rst_n)
        back_st.fire |-> item_valid)
        else $error("back end fired with no queued beat");

    // a matrix copy happens only as the countdown reaches zero
    a_copy_zero: assert property (@(posedge clk) disable iff (!rst_n)
        back_st.copy |=> (back_st.countdown == '0))
        else $error("matrix copy without countdown reaching zero");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        back_st.fire |=> !empty)
        else $error("result queue empty after back end fired");

endmodule
